// ----- sv/fstm_pkg.sv -----
// shared types and constants for the fan speed trimmed-mean filter
`default_nettype none
package fstm_pkg;

   localparam int RING_DEPTH  = 7;
   localparam int WORD_W      = 16;
   localparam int COUNT_W     = $clog2(RING_DEPTH);
   localparam int SPEED_SCALE = 30;
   localparam int SCALE_W     = 5;
   localparam int TRIM_DROP   = 1 + 2;
   localparam int TRIM_DIV    = (RING_DEPTH > TRIM_DROP) ? (RING_DEPTH - TRIM_DROP) : 1;

   // floor(x * RECIP_MULT >> RECIP_SHIFT) equals x / TRIM_DIV for every 16-bit x
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 21;
   localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + TRIM_DIV - 1) / TRIM_DIV;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIVIDE,
      ST_SCALE
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } acc_ctrl_type;

endpackage
`default_nettype wire

// ----- sv/fstm_cell.sv -----
// one snapshot cell of the ring, shifts toward the oldest end when enabled
`default_nettype none
module fstm_cell (
   input  wire              clock,
   input  wire              reset,
   input  wire              shift_en,
   input  fstm_pkg::word_type data_in,
   output fstm_pkg::word_type data_out
);
   import fstm_pkg::*;

   word_type value_ff;
   word_type value_in;

   always_comb begin
      value_in = shift_en ? data_in : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign data_out = value_ff;

endmodule
`default_nettype wire

// ----- sv/fstm_accum.sv -----
// running sum, largest and smallest of the differences, trimmed sum out
`default_nettype none
module fstm_accum (
   input  wire                  clock,
   input  fstm_pkg::acc_ctrl_type ctrl,
   input  fstm_pkg::word_type   diff,
   output fstm_pkg::word_type   trimmed
);
   import fstm_pkg::*;

   word_type sum_ff, sum_in;
   word_type hi_ff, hi_in;
   word_type lo_ff, lo_in;

   always_comb begin
      sum_in = sum_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         hi_in  = '0;
         lo_in  = '1;
      end else if (ctrl.step) begin
         sum_in = sum_ff + diff;
         if (diff > hi_ff) begin
            hi_in = diff;
         end
         if (diff < lo_ff) begin
            lo_in = diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign trimmed = sum_ff - hi_ff - lo_ff;

endmodule
`default_nettype wire

// ----- sv/fan_speed_trimmed_mean.sv -----
// top level of the fan speed trimmed-mean filter
//
// req channel: one counter_snapshot item per measuring interval, valid/ready.
// rsp channel: one speed_rpm item per accepted snapshot, valid/ready.
// The snapshots sit in a row of cells, oldest at the head. An accepted item
// shifts in at the tail, then the row rotates once around, one cell a cycle,
// while the head pair feeds the sum/min/max unit with one difference a cycle.
// From the accepting edge to rsp_valid an item passes the rotation of the row,
// the quotient register behind the reciprocal multiplier for the trimmed
// division and the times-30 multiplier into the output register.
// A new item is taken only once the last result has left the final stage:
// req_ready is high only while no item is in the walk or the multipliers.
// The result waits in an output register; a new item can be taken while it
// waits, and a stalled receiver holds the next result in the final stage
// until the register frees up.
// Reset clears the ring to zero, so the first results mix in differences
// against zero; rsp_valid drops and req_ready rises after reset.
`default_nettype none
module fan_speed_trimmed_mean (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  fstm_pkg::word_type req_counter_snapshot,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output fstm_pkg::word_type rsp_speed_rpm
);
   import fstm_pkg::*;

   localparam logic [COUNT_W-1:0] LAST_COUNT  = COUNT_W'(RING_DEPTH - 1);
   localparam logic [RECIP_W-1:0] RECIP_CONST = RECIP_W'(RECIP_MULT);
   localparam logic [SCALE_W-1:0] SCALE_CONST = SCALE_W'(SPEED_SCALE);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   word_type           quot_ff, quot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_speed_rpm_ff, rsp_speed_rpm_in;

   word_type     cell_q [RING_DEPTH];
   word_type     cell_d [RING_DEPTH];
   logic         shift_en;
   word_type     diff;
   word_type     trimmed;
   acc_ctrl_type acc_ctrl;

   logic [WORD_W+RECIP_W-1:0] recip_prod;
   logic [WORD_W+SCALE_W-1:0] scale_prod;

   // row of cells; the tail takes the new item or wraps the head around
   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
      if (i == RING_DEPTH - 1) begin : g_tail
         assign cell_d[i] = (state_ff == ST_WALK) ? cell_q[0] : req_counter_snapshot;
      end else begin : g_body
         assign cell_d[i] = cell_q[i+1];
      end
      fstm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .data_in  (cell_d[i]),
         .data_out (cell_q[i])
      );
   end

   assign diff = cell_q[1] - cell_q[0];

   fstm_accum u_accum (
      .clock   (clock),
      .ctrl    (acc_ctrl),
      .diff    (diff),
      .trimmed (trimmed)
   );

   assign recip_prod = trimmed * RECIP_CONST;
   assign scale_prod = quot_ff * SCALE_CONST;

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      quot_in          = quot_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_speed_rpm_in = rsp_speed_rpm_ff;
      req_ready        = 1'b0;
      shift_en         = 1'b0;
      acc_ctrl.clear   = 1'b0;
      acc_ctrl.step    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               shift_en       = 1'b1;
               acc_ctrl.clear = 1'b1;
               count_in       = '0;
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            shift_en = 1'b1;
            // the last rotation only restores order, no difference left
            acc_ctrl.step = (count_ff != LAST_COUNT);
            count_in      = count_ff + 1'b1;
            if (count_ff == LAST_COUNT) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quot_in  = recip_prod[RECIP_SHIFT +: WORD_W];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_speed_rpm_in = scale_prod[WORD_W-1:0];
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff          <= quot_in;
      rsp_speed_rpm_ff <= rsp_speed_rpm_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_rpm = rsp_speed_rpm_ff;

endmodule
`default_nettype wire

// ----- sv/fstm_checker.sv -----
// port-level checks for the fan speed trimmed-mean filter, bound to the top
`default_nettype none
module fstm_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input fstm_pkg::word_type req_counter_snapshot,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input fstm_pkg::word_type rsp_speed_rpm
);
   import fstm_pkg::*;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_rpm))
      else $error("rsp item changed or dropped while stalled");

   // a waiting req item stays put until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_counter_snapshot))
      else $error("req item changed or dropped while waiting");

   // an accepted item keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted item");

   // reset leaves no result pending and the input open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("outputs not cleared by reset");

endmodule

bind fan_speed_trimmed_mean fstm_checker u_fstm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_counter_snapshot (req_counter_snapshot),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_speed_rpm        (rsp_speed_rpm)
);
`default_nettype wire

// ----- tb/sv/fan_speed_trimmed_mean_test.sv -----
// self-checking testbench for the fan speed trimmed-mean filter
`default_nettype none
module fan_speed_trimmed_mean_test;
   import fstm_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   word_type req_counter_snapshot = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_speed_rpm;

   // own copy of the snapshot ring
   word_type ring_copy [RING_DEPTH];
   int       ring_head = 0;

   word_type expected_rpm_q [$];
   int       sender_idle_pct = 0;
   int       receiver_idle_pct = 0;
   logic     hold_start = 1'b0;
   int       hold_left = 0;
   int       stall_cycles = 0;
   int       error_count = 0;
   int       items_sent = 0;
   int       results_checked = 0;
   word_type tach_count = '0;
   word_type tach_rate = '0;

   fan_speed_trimmed_mean dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_counter_snapshot (req_counter_snapshot),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_speed_rpm        (rsp_speed_rpm)
   );

   always #5 clock = ~clock;

   // store the snapshot, then walk oldest to newest and form the trimmed mean times 30
   function automatic word_type predict_speed_rpm(input word_type snapshot);
      word_type prev;
      word_type cur;
      word_type diff;
      word_type sum;
      word_type hi;
      word_type lo;
      int       pos;
      int       divisor;
      ring_copy[ring_head] = snapshot;
      ring_head = (ring_head + 1 == RING_DEPTH) ? 0 : ring_head + 1;
      pos = ring_head;
      cur = ring_copy[pos];
      sum = '0;
      hi = '0;
      lo = '1;
      for (int k = 1; k < RING_DEPTH; k++) begin
         prev = cur;
         pos = (pos + 1 == RING_DEPTH) ? 0 : pos + 1;
         cur = ring_copy[pos];
         diff = cur - prev;
         if (diff > hi) hi = diff;
         if (diff < lo) lo = diff;
         sum = sum + diff;
      end
      divisor = (RING_DEPTH > 3) ? RING_DEPTH - 3 : 1;
      sum = sum - hi - lo;
      return word_type'((int'(sum) / divisor) * 30);
   endfunction

   task automatic send_snapshot(input word_type value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_counter_snapshot <= value;
      do @(posedge clock); while (!req_ready);
      expected_rpm_q.push_back(predict_speed_rpm(value));
      items_sent++;
   endtask

   task automatic stop_sending;
      req_valid <= 1'b0;
   endtask

   // ring starts at zero, so the first speeds include differences against zero
   task automatic test_startup_from_zero;
      send_snapshot(16'd30);
      send_snapshot(16'd60);
      send_snapshot(16'd90);
      stop_sending();
   endtask

   task automatic test_counter_wrap;
      word_type value;
      value = 16'hFE00;
      for (int i = 0; i < 7; i++) begin
         send_snapshot(value);
         value = value + 16'h0090;
      end
      stop_sending();
   endtask

   // large steps make the sum and the times-30 product wrap
   task automatic test_sum_overflow;
      word_type value;
      value = 16'h1234;
      for (int i = 0; i < 6; i++) begin
         value = value + 16'hB000;
         send_snapshot(value);
      end
      stop_sending();
   endtask

   task automatic test_field_extremes;
      send_snapshot(16'hFFFF);
      send_snapshot(16'h0000);
      send_snapshot(16'hFFFF);
      send_snapshot(16'h0000);
      stop_sending();
   endtask

   // mostly a steadily running counter with jitter, now and then a glitch sample
   task automatic test_random_run(input int n_items, input int send_pct, input int recv_pct);
      word_type value;
      int       pick;
      sender_idle_pct = send_pct;
      receiver_idle_pct <= recv_pct;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) begin
            if ($urandom_range(3) == 0) tach_rate = word_type'($urandom);
            else tach_rate = word_type'($urandom_range(2500));
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            value = word_type'($urandom);
         end else begin
            tach_count = tach_count + tach_rate + word_type'($urandom_range(40)) - 16'd20;
            value = tach_count;
         end
         send_snapshot(value);
      end
      stop_sending();
   endtask

   // receiver holds off while items keep coming, so the input has to stall
   task automatic test_output_backpressure;
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      for (int i = 0; i < 24; i++) begin
         tach_count = tach_count + word_type'($urandom_range(3000));
         send_snapshot(tach_count);
      end
      stop_sending();
   endtask

   always @(posedge clock) begin : rsp_side
      word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rpm_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected speed_rpm item, actual %0d", $time, rsp_speed_rpm);
         end else begin
            want = expected_rpm_q.pop_front();
            results_checked++;
            if (rsp_speed_rpm !== want) begin
               error_count++;
               $display("%0t: speed_rpm mismatch, expected %0d actual %0d",
                        $time, want, rsp_speed_rpm);
            end
         end
      end
      if (hold_start) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 17;
      receiver_idle_pct <= 75;
      test_startup_from_zero();
      test_counter_wrap();
      test_sum_overflow();
      test_field_extremes();
      test_random_run(200, 17, 75);
      test_random_run(200, 75, 17);
      test_random_run(200, 0, 0);
      test_output_backpressure();
      while (expected_rpm_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered start-up from a zero ring, counter wrap, sum and product overflow,");
      $display("random tach rates with glitches, three idle mixes and a long output stall:");
      $display("%0d snapshots sent, %0d speeds checked, %0d errors",
               items_sent, results_checked, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
sv/fstm_pkg.sv
sv/fstm_cell.sv
sv/fstm_accum.sv
sv/fan_speed_trimmed_mean.sv
sv/fstm_checker.sv
tb/sv/fan_speed_trimmed_mean_test.sv
